>>> sv/crc24wv_pkg.sv
// types, constants and the word update function of the crc-24 word checksum verifier
`default_nettype none

package crc24wv_pkg;

    // generator polynomial, the top bit is implicit
    localparam logic [23:0] POLY24 = 24'h80001B;

    // status reported with each checksum
    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_ZERO     = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    // one 16-bit word into the running register: shift, fold in word, reduce
    function automatic logic [23:0] crc_word_step(input logic [23:0] crc,
                                                  input logic [15:0] word);
        logic [23:0] shifted;
        begin
            shifted = {crc[22:0], 1'b0} ^ {8'd0, word};
            if (crc[23])
            begin
                shifted = shifted ^ POLY24;
            end
            return shifted;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/crc24_word_checksum_verify.sv
// top level of the crc-24 word checksum verifier
//
// Usage:
//   Bytes arrive on the s_axis stream, one per transaction, with tlast on the
//   final byte of a stream. Bytes are paired low then high into 16-bit words,
//   each word updating a 24-bit crc (polynomial 0x80001B); an odd final byte
//   is paired with a zero high byte.
//   For each stream one transaction leaves on m_axis: tdata carries the
//   checksum, tuser the status (match, zero checksum, or mismatch against the
//   value last written through cfg_we / cfg_wdata).
//   Throughput is one byte per cycle, except that a final byte waits while an
//   earlier result has not been taken; the whole update runs between the input
//   register and the result register. m_axis_tvalid rises once the transaction
//   carrying tlast has passed the input register, then the result register.
//   When the receiver stalls the result is held in the output register; the
//   block keeps taking non-final bytes of the next stream, and holds a further
//   final byte in its input register until the result has been taken.
//   Reset clears the crc, any held byte, the expected value and both
//   pipeline registers; no result is pending after reset.
`default_nettype none

module crc24_word_checksum_verify (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: expected checksum
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result out
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // [23:0] checksum
    output      logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic        expected_reg;
    logic [23:0] expected_crc_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [23:0] crc_reg;
    logic [7:0]  held_reg;
    logic        pending_reg;

    logic                  out_valid_reg;
    logic [23:0]           out_checksum_reg;
    crc24wv_pkg::status_t  out_status_reg;

    logic                  s_accept;
    logic                  advance;
    logic [15:0]           word;
    logic [23:0]           crc_next;
    crc24wv_pkg::status_t  status_next;

    assign expected_reg = 1'b1;

    // expected checksum register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_crc_reg <= 24'd0;
        end
        else if (cfg_we && expected_reg)
        begin
            expected_crc_reg <= cfg_wdata;
        end
    end

    // handshake: the input register moves on unless a final byte meets a full output
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // word assembly and crc update
    always_comb
    begin
        word     = pending_reg ? {in_byte_reg, held_reg} : {8'd0, in_byte_reg};
        crc_next = crc24wv_pkg::crc_word_step(crc_reg, word);
        if (crc_next == 24'd0)
        begin
            status_next = crc24wv_pkg::STATUS_ZERO;
        end
        else if (crc_next != expected_crc_reg)
        begin
            status_next = crc24wv_pkg::STATUS_MISMATCH;
        end
        else
        begin
            status_next = crc24wv_pkg::STATUS_MATCH;
        end
    end

    // running crc and held low byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= 24'd0;
            held_reg    <= 8'd0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                crc_reg     <= 24'd0;
                held_reg    <= 8'd0;
                pending_reg <= 1'b0;
            end
            else if (pending_reg)
            begin
                crc_reg     <= crc_next;
                held_reg    <= 8'd0;
                pending_reg <= 1'b0;
            end
            else
            begin
                held_reg    <= in_byte_reg;
                pending_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_checksum_reg <= crc_next;
            out_status_reg   <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_checksum_reg;
    assign m_axis_tuser  = out_status_reg;

    // a new result only follows a final byte leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a final byte");

    // zero status exactly when the checksum is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_checksum_reg == 24'd0)
                           == (out_status_reg == crc24wv_pkg::STATUS_ZERO)))
        else $error("zero status disagrees with checksum");

    // a match is reported only when the checksum equals the expected value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == crc24wv_pkg::STATUS_MATCH)
            |-> (out_checksum_reg == expected_crc_reg))
        else $error("match reported on differing checksum");

    // state is cleared after each stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (!pending_reg && crc_reg == 24'd0))
        else $error("crc state not cleared at end of stream");

    // a final byte never overwrites a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
